@@ rtl/cba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg
// shared types, constants and helpers for the charge bargraph animator
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int LED_COUNT   = 10;
  localparam int DELAY_WIDTH = 24;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  // odd/even multiplex masks
  localparam logic [LED_COUNT-1:0] MASK_ODD  = LED_COUNT'(10'h155);
  localparam logic [LED_COUNT-1:0] MASK_EVEN = LED_COUNT'(10'h2AA);

  // charge scaling
  localparam logic [15:0] SOC_ONE   = 16'd16384;
  localparam logic [4:0]  LEVEL_TOP = 5'd19;

  // input operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // register indexes
  localparam logic [2:0] REG_MUX_PERIOD     = 3'd0;
  localparam logic [2:0] REG_CRIT_HALF      = 3'd1;
  localparam logic [2:0] REG_CRIT_COUNT     = 3'd2;
  localparam logic [2:0] REG_BUILDUP_PERIOD = 3'd3;
  localparam logic [2:0] REG_FLASH_HALF     = 3'd4;
  localparam logic [2:0] REG_FLASH_COUNT    = 3'd5;

  typedef struct packed {
    logic [7:0]  mux_period;
    logic [15:0] critical_half_period;
    logic [7:0]  crit_flashes;
    logic [15:0] buildup_period;
    logic [15:0] flash_half_period;
    logic [7:0]  flash_toggle_count;
  } cba_cfg_t;

  typedef struct packed {
    logic               op;
    logic signed [15:0] soc;
    logic               soc_present;
  } cba_item_t;

  function automatic logic [7:0] min1_8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [15:0] min1_16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

@@ rtl/cba_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_regs
// apb-style configuration registers with readback
// ----------------------------------------------------------------------------
module cba_regs import cba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cba_cfg_t          cfg
);

  cba_cfg_t   cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mux_period           <= 8'd2;
      cfg_r.critical_half_period <= 16'd75;
      cfg_r.crit_flashes         <= 8'd10;
      cfg_r.buildup_period       <= 16'd50;
      cfg_r.flash_half_period    <= 16'd500;
      cfg_r.flash_toggle_count   <= 8'd8;
    end else if (wr_en) begin
      unique case (idx)
        REG_MUX_PERIOD:     cfg_r.mux_period           <= pwdata[7:0];
        REG_CRIT_HALF:      cfg_r.critical_half_period <= pwdata[15:0];
        REG_CRIT_COUNT:     cfg_r.crit_flashes         <= pwdata[7:0];
        REG_BUILDUP_PERIOD: cfg_r.buildup_period       <= pwdata[15:0];
        REG_FLASH_HALF:     cfg_r.flash_half_period    <= pwdata[15:0];
        REG_FLASH_COUNT:    cfg_r.flash_toggle_count   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MUX_PERIOD:     prdata = DATA_W'(cfg_r.mux_period);
      REG_CRIT_HALF:      prdata = DATA_W'(cfg_r.critical_half_period);
      REG_CRIT_COUNT:     prdata = DATA_W'(cfg_r.crit_flashes);
      REG_BUILDUP_PERIOD: prdata = DATA_W'(cfg_r.buildup_period);
      REG_FLASH_HALF:     prdata = DATA_W'(cfg_r.flash_half_period);
      REG_FLASH_COUNT:    prdata = DATA_W'(cfg_r.flash_toggle_count);
      default:            prdata = '0;
    endcase
  end

endmodule

@@ rtl/cba_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_engine
// animation state and single-pass next-state logic for one beat
// ----------------------------------------------------------------------------
module cba_engine import cba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  cba_item_t            item,
  input  cba_cfg_t             cfg,
  output logic [LED_COUNT-1:0] pins_nxt,
  output logic                 busy_nxt
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CRIT,
    PH_BUILD,
    PH_HOLD,
    PH_FLASH
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [LED_COUNT-1:0]   led_buffer;
    logic [4:0]             level;
    logic [15:0]            stored_charge;
    logic [7:0]             step_count;
    logic [DELAY_WIDTH-1:0] delay_count;
    logic [7:0]             mux_count;
    logic                   mux_polarity;
    logic [LED_COUNT-1:0]   pin_register;
  } st_t;

  localparam int PROD_W = 24;
  localparam logic [DELAY_WIDTH-1:0] DELAY_MAX = '1;

  st_t st_r, st_nxt;

  function automatic logic [LED_COUNT-1:0] top_bit(input logic [4:0] lvl);
    return LED_COUNT'(1) << lvl[4:1];
  endfunction

  function automatic logic [DELAY_WIDTH-1:0] hold_delay(input cba_cfg_t c);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(min1_16(c.flash_half_period)) * PROD_W'(min1_8(c.flash_toggle_count));
    if (PROD_W > DELAY_WIDTH && (prod >> DELAY_WIDTH) != '0)
      return DELAY_MAX;
    return DELAY_WIDTH'(prod);
  endfunction

  function automatic st_t enter_top(input st_t s, input cba_cfg_t c);
    st_t t;
    t = s;
    if (s.level[0]) begin
      t.phase       = PH_HOLD;
      t.led_buffer  = s.led_buffer | top_bit(s.level);
      t.delay_count = hold_delay(c);
    end else begin
      t.phase       = PH_FLASH;
      t.step_count  = 8'd1;
      t.led_buffer  = s.led_buffer ^ top_bit(s.level);
      t.delay_count = DELAY_WIDTH'(min1_16(c.flash_half_period));
    end
    return t;
  endfunction

  function automatic st_t build_next(input st_t s, input cba_cfg_t c);
    st_t t;
    t = s;
    if (s.step_count < 8'(s.level[4:1])) begin
      t.led_buffer  = s.led_buffer | (LED_COUNT'(1) << s.step_count[3:0]);
      t.step_count  = s.step_count + 8'd1;
      t.delay_count = DELAY_WIDTH'(min1_16(c.buildup_period));
    end else begin
      t = enter_top(s, c);
    end
    return t;
  endfunction

  function automatic st_t do_start(input st_t s, input cba_cfg_t c);
    st_t         t;
    logic [18:0] scaled;
    t      = s;
    scaled = {1'b0, s.stored_charge[13:0], 4'b0} + {3'b0, s.stored_charge[13:0], 2'b0};
    if (s.stored_charge[15])
      t.level = 5'd0;
    else if (s.stored_charge >= SOC_ONE)
      t.level = LEVEL_TOP;
    else
      t.level = scaled[18:14];
    t.led_buffer = '0;
    t.step_count = 8'd0;
    t.mux_count  = 8'd0;
    if (t.level == 5'd0) begin
      t.phase       = PH_CRIT;
      t.led_buffer  = LED_COUNT'(1);
      t.delay_count = DELAY_WIDTH'(min1_16(c.critical_half_period));
    end else begin
      t.phase = PH_BUILD;
      t = build_next(t, c);
    end
    return t;
  endfunction

  function automatic st_t do_advance(input st_t s, input cba_cfg_t c);
    st_t t;
    t = s;
    unique case (s.phase)
      PH_CRIT: begin
        if (s.led_buffer[0]) begin
          t.led_buffer  = '0;
          t.delay_count = DELAY_WIDTH'(min1_16(c.critical_half_period));
        end else begin
          t.step_count = s.step_count + 8'd1;
          if (t.step_count >= min1_8(c.crit_flashes)) begin
            t.phase        = PH_IDLE;
            t.pin_register = '0;
          end else begin
            t.led_buffer  = LED_COUNT'(1);
            t.delay_count = DELAY_WIDTH'(min1_16(c.critical_half_period));
          end
        end
      end
      PH_BUILD: t = build_next(s, c);
      PH_FLASH: begin
        if (s.step_count >= min1_8(c.flash_toggle_count)) begin
          t.phase        = PH_IDLE;
          t.pin_register = '0;
        end else begin
          t.led_buffer  = s.led_buffer ^ top_bit(s.level);
          t.step_count  = s.step_count + 8'd1;
          t.delay_count = DELAY_WIDTH'(min1_16(c.flash_half_period));
        end
      end
      default: begin
        t.phase        = PH_IDLE;
        t.pin_register = '0;
      end
    endcase
    return t;
  endfunction

  function automatic st_t do_mux(input st_t s, input cba_cfg_t c);
    st_t t;
    t = s;
    if (s.mux_count == 8'd0) begin
      t.pin_register = s.led_buffer & (s.mux_polarity ? MASK_ODD : MASK_EVEN);
      t.mux_polarity = ~s.mux_polarity;
      t.mux_count    = min1_8(c.mux_period) - 8'd1;
    end else begin
      t.mux_count = s.mux_count - 8'd1;
    end
    return t;
  endfunction

  always_comb begin
    st_nxt = st_r;
    if (item.op == OP_START) begin
      if (st_r.phase == PH_IDLE) begin
        if (item.soc_present)
          st_nxt.stored_charge = item.soc;
        st_nxt = do_start(st_nxt, cfg);
      end
    end else if (st_r.phase != PH_IDLE) begin
      st_nxt.delay_count = st_r.delay_count - DELAY_WIDTH'(1);
      if (st_nxt.delay_count == '0)
        st_nxt = do_advance(st_nxt, cfg);
      if (st_nxt.phase != PH_IDLE)
        st_nxt = do_mux(st_nxt, cfg);
    end
  end

  assign pins_nxt = st_nxt.pin_register;
  assign busy_nxt = (st_nxt.phase != PH_IDLE);

  // all-zero state is idle with a cleared buffer and pins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ rtl/charge_bargraph_animator.sv @@
`timescale 1ns / 1ps
// path: input register, then engine update and result register, both advanced by fire
// throughput: one beat per cycle while out_ready, set by the single-pass engine update
// an output register parts the sides, so one more beat is taken while a result waits
// reset: synchronous active-low rst_n clears pipeline valids and animation state,
// and loads the configuration defaults
// ----------------------------------------------------------------------------
// charge_bargraph_animator
// ten-led charge bargraph animator with odd/even multiplexing
// ----------------------------------------------------------------------------
module charge_bargraph_animator import cba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic signed [15:0]   in_soc,
  input  logic                 in_soc_present,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LED_COUNT-1:0] out_led_pins,
  output logic                 out_busy_res,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  cba_cfg_t             cfg;
  cba_item_t            item_r;
  logic                 in_valid_r;
  logic                 out_valid_r;
  logic [LED_COUNT-1:0] pins_r;
  logic                 busy_r;
  logic [LED_COUNT-1:0] pins_nxt;
  logic                 busy_nxt;
  logic                 fire;

  // the held beat moves on when the result slot is empty or being drained
  assign fire     = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | fire;

  cba_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cba_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (item_r),
    .cfg      (cfg),
    .pins_nxt (pins_nxt),
    .busy_nxt (busy_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.op          <= in_op;
      item_r.soc         <= in_soc;
      item_r.soc_present <= in_soc_present;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pins_r <= pins_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_led_pins = pins_r;
  assign out_busy_res = busy_r;

endmodule
